// ----- hdl/ecbu_pkg.sv -----
// Package for the camera basis update block: command types, fixed-point
// constants and the sine series used to build the sine and cosine tables.
// No dependencies; used by every module of the block.
`default_nettype none

package ecbu_pkg;

    // Function codes carried in the input word's tuser.
    localparam logic [2:0] FN_FWD   = 3'd0;
    localparam logic [2:0] FN_BACK  = 3'd1;
    localparam logic [2:0] FN_LEFT  = 3'd2;
    localparam logic [2:0] FN_RIGHT = 3'd3;
    localparam logic [2:0] FN_UP    = 3'd4;
    localparam logic [2:0] FN_DOWN  = 3'd5;
    localparam logic [2:0] FN_TURN  = 3'd6;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SCREEN_W = 2'd0;
    localparam logic [1:0] CFG_SCREEN_H = 2'd1;
    localparam logic [1:0] CFG_ROLL     = 2'd2;

    // Angle lanes of the trig sequence.
    localparam logic [1:0] LANE_YAW   = 2'd0;
    localparam logic [1:0] LANE_PITCH = 2'd1;
    localparam logic [1:0] LANE_ROLL  = 2'd2;

    // Datapath widths.
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = 58;
    localparam int ACC_W   = 48;
    localparam int WIDE_W  = 60;

    // Angle constants in Q16 degrees.
    localparam logic signed [31:0] HALF_TURN = 32'sd11796480;
    localparam logic signed [24:0] PITCH_LIM = 25'sd5832704;
    localparam logic signed [24:0] YAW_RST   = 25'sd11796480;
    localparam logic signed [24:0] PITCH_RST = -25'sd5832704;

    // Division by 360 through a reciprocal: q = (n * RECIP_360) >> 31.
    localparam logic signed [24:0] RECIP_360   = 25'sd5965233;
    localparam int                 RECIP_SHIFT = 31;
    // Biases that keep the dividends positive.
    localparam logic signed [31:0] WRAP_BIAS = 32'sd23040;
    localparam logic signed [31:0] IDX_BIAS  = 32'sd1474740;
    localparam logic signed [14:0] IDX_OFF   = 15'sd4096;

    localparam logic signed [15:0] V_ONE = 16'sd16384;

    // Q28 radian constants for the sine series.
    localparam longint ONE_Q28     = 64'sd268435456;
    localparam longint PI_Q28      = 64'sd843314857;
    localparam longint HALF_PI_Q28 = 64'sd421657428;
    localparam longint TWO_PI_Q28  = 64'sd1686629713;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_MOVE_MUL,
        OP_MOVE_ADD,
        OP_VERT,
        OP_YAW_MUL,
        OP_YAW_SUM,
        OP_PITCH_SUM,
        OP_YAW_WRAP,
        OP_TRIG_MUL,
        OP_TRIG_RECIP,
        OP_TRIG_IDX,
        OP_TRIG_ROM,
        OP_VEC,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] lane;
        logic [3:0] step;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOVE_MUL,
        ST_MOVE_ADD,
        ST_VERT,
        ST_YAW_MUL,
        ST_YAW_SUM,
        ST_PITCH_SUM,
        ST_YAW_WRAP,
        ST_TRIG_MUL,
        ST_TRIG_RECIP,
        ST_TRIG_IDX,
        ST_TRIG_ROM,
        ST_VEC,
        ST_DONE
    } ctl_state_t;

    // Sine in Q14 of an angle in Q28 radians within [0, 2.5 pi).
    function automatic logic signed [15:0] sine_q14(input longint theta_in);
        longint th;
        longint x;
        longint ax;
        longint x2;
        longint t;
        longint s;
        th = theta_in;
        if (th >= TWO_PI_Q28) begin
            th = th - TWO_PI_Q28;
        end
        x = (th > PI_Q28) ? th - TWO_PI_Q28 : th;
        if (x > HALF_PI_Q28) begin
            x = PI_Q28 - x;
        end else if (x < -HALF_PI_Q28) begin
            x = -PI_Q28 - x;
        end
        ax = (x < 0) ? -x : x;
        x2 = (ax * ax) >>> 28;
        t  = ONE_Q28;
        t  = ONE_Q28 - ((x2 * t) >>> 28) / 110;
        t  = ONE_Q28 - ((x2 * t) >>> 28) / 72;
        t  = ONE_Q28 - ((x2 * t) >>> 28) / 42;
        t  = ONE_Q28 - ((x2 * t) >>> 28) / 20;
        t  = ONE_Q28 - ((x2 * t) >>> 28) / 6;
        s  = (ax * t) >>> 28;
        s  = (s + 8192) >>> 14;
        if (s < 0) begin
            s = 0;
        end
        if (s > 16384) begin
            s = 16384;
        end
        if (x < 0) begin
            s = -s;
        end
        return 16'(s);
    endfunction

    // Shift right by n, rounding half away from zero.
    function automatic logic signed [WIDE_W-1:0] rnd_shift(input logic signed [WIDE_W-1:0] v,
                                                          input logic [4:0] n);
        logic signed [WIDE_W-1:0] half;
        half = 60'sd1 <<< (n - 5'd1);
        if (v >= 0) begin
            return (v + half) >>> n;
        end
        return -((-v + half) >>> n);
    endfunction

    // Saturate to the unit vector range.
    function automatic logic signed [15:0] sat_vec(input logic signed [WIDE_W-1:0] v);
        if (v > 60'sd16384) begin
            return V_ONE;
        end
        if (v < -60'sd16384) begin
            return -V_ONE;
        end
        return v[15:0];
    endfunction

    // Saturate a position sum to 32 bits.
    function automatic logic signed [31:0] sat_pos(input logic signed [33:0] v);
        if (v > 34'sd2147483647) begin
            return 32'sh7fffffff;
        end
        if (v < -34'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

`default_nettype wire

// ----- hdl/ecbu_ctrl.sv -----
// Controller of the camera basis update: sequences datapath operations for
// each event and owns the input ready and output valid handshakes.
// Depends on ecbu_pkg.
`default_nettype none

module ecbu_ctrl
    import ecbu_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    input  wire logic [2:0] s_tuser,
    output logic            s_tready,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output cmd_t            cmd
);

    ctl_state_t state_reg, state_next;
    logic [1:0] lane_reg, lane_next;
    logic [3:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;

    // State, lane, step and output valid registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            lane_reg      <= 2'd0;
            step_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            lane_reg      <= lane_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and command decode.
    always_comb begin
        state_next     = state_reg;
        lane_next      = lane_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !m_tready;
        s_tready       = 1'b0;
        cmd.op         = OP_IDLE;
        cmd.lane       = lane_reg;
        cmd.step       = step_reg;
        case (state_reg)
            ST_IDLE: begin
                // No word is taken while reset is held.
                s_tready  = aresetn;
                lane_next = 2'd0;
                step_next = 4'd0;
                if (s_tvalid && aresetn) begin
                    cmd.op = OP_LOAD;
                    case (s_tuser)
                        FN_FWD, FN_BACK, FN_LEFT, FN_RIGHT: state_next = ST_MOVE_MUL;
                        FN_UP, FN_DOWN:                     state_next = ST_VERT;
                        FN_TURN:                            state_next = ST_YAW_MUL;
                        default:                            state_next = ST_DONE;
                    endcase
                end
            end
            ST_MOVE_MUL: begin
                cmd.op     = OP_MOVE_MUL;
                state_next = ST_MOVE_ADD;
            end
            ST_MOVE_ADD: begin
                cmd.op = OP_MOVE_ADD;
                if (lane_reg == LANE_ROLL) begin
                    state_next = ST_DONE;
                end else begin
                    lane_next  = lane_reg + 2'd1;
                    state_next = ST_MOVE_MUL;
                end
            end
            ST_VERT: begin
                cmd.op     = OP_VERT;
                state_next = ST_DONE;
            end
            ST_YAW_MUL: begin
                cmd.op     = OP_YAW_MUL;
                state_next = ST_YAW_SUM;
            end
            ST_YAW_SUM: begin
                cmd.op     = OP_YAW_SUM;
                state_next = ST_PITCH_SUM;
            end
            ST_PITCH_SUM: begin
                cmd.op     = OP_PITCH_SUM;
                state_next = ST_YAW_WRAP;
            end
            ST_YAW_WRAP: begin
                cmd.op     = OP_YAW_WRAP;
                state_next = ST_TRIG_MUL;
            end
            ST_TRIG_MUL: begin
                cmd.op     = OP_TRIG_MUL;
                state_next = ST_TRIG_RECIP;
            end
            ST_TRIG_RECIP: begin
                cmd.op     = OP_TRIG_RECIP;
                state_next = ST_TRIG_IDX;
            end
            ST_TRIG_IDX: begin
                cmd.op     = OP_TRIG_IDX;
                state_next = ST_TRIG_ROM;
            end
            ST_TRIG_ROM: begin
                cmd.op = OP_TRIG_ROM;
                if (lane_reg == LANE_ROLL) begin
                    step_next  = 4'd0;
                    state_next = ST_VEC;
                end else begin
                    lane_next  = lane_reg + 2'd1;
                    state_next = ST_TRIG_MUL;
                end
            end
            ST_VEC: begin
                cmd.op    = OP_VEC;
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd15) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Load the output register once it is free or being taken.
                if (!out_valid_reg || m_tready) begin
                    cmd.op         = OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

// ----- hdl/ecbu_datapath.sv -----
// Datapath of the camera basis update: pose and angle registers, one shared
// multiplier, the divide-by-360 reciprocal path and the sine/cosine tables.
// Depends on ecbu_pkg.
`default_nettype none

module ecbu_datapath
    import ecbu_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cmd_t        cmd,
    input  wire logic [39:0] s_tdata,
    input  wire logic [2:0]  s_tuser,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [12:0] cfg_wdata,
    output logic [239:0]     m_tdata
);

    localparam int                 IDX_W   = $clog2(SINE_TABLE_DEPTH);
    localparam logic signed [14:0] DEPTH_S = 15'(SINE_TABLE_DEPTH);

    // Constant sine and cosine tables, one entry per angle step.
    logic signed [15:0] sin_rom [SINE_TABLE_DEPTH];
    logic signed [15:0] cos_rom [SINE_TABLE_DEPTH];

    for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++) begin : g_rom
        localparam longint THETA = (longint'(gi) * TWO_PI_Q28) / SINE_TABLE_DEPTH;
        assign sin_rom[gi] = sine_q14(THETA);
        assign cos_rom[gi] = sine_q14(THETA + HALF_PI_Q28);
    end

    // Registers.
    logic [2:0]               func_reg, func_next;
    logic [15:0]              dt_reg, dt_next;
    logic [11:0]              mx_reg, mx_next;
    logic [11:0]              my_reg, my_next;
    logic [12:0]              scr_w_reg, scr_w_next;
    logic [12:0]              scr_h_reg, scr_h_next;
    logic signed [8:0]        roll_reg, roll_next;
    logic signed [31:0]       pos_reg [3];
    logic signed [31:0]       pos_next [3];
    logic signed [15:0]       fwd_reg [3];
    logic signed [15:0]       fwd_next [3];
    logic signed [15:0]       up_reg [3];
    logic signed [15:0]       up_next [3];
    logic signed [15:0]       rgt_reg [3];
    logic signed [15:0]       rgt_next [3];
    logic signed [24:0]       yaw_reg, yaw_next;
    logic signed [24:0]       pitch_reg, pitch_next;
    logic signed [31:0]       ang_reg, ang_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [29:0]       w_reg, w_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic signed [15:0]       sin_reg [3];
    logic signed [15:0]       sin_next [3];
    logic signed [15:0]       cos_reg [3];
    logic signed [15:0]       cos_next [3];
    logic [239:0]             out_reg, out_next;

    // Shared multiplier.
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic                      mul_en;

    assign mul_p = mul_a * mul_b;

    // Derived values.
    logic [11:0]              cx, cy;
    logic signed [13:0]       x_off, y_off;
    logic signed [31:0]       wrap_num, trig_num, wrap_rem;
    logic signed [26:0]       quot;
    logic signed [14:0]       idx_raw, idx_fix;
    logic signed [31:0]       yaw_wrap;
    logic signed [33:0]       ang_sum, pitch_sum, pos_sum, vert_sum;
    logic signed [WIDE_W-1:0] mv_d;
    logic signed [15:0]       mv_vec;
    logic                     mv_neg;
    logic signed [MUL_A_W-1:0] deg_sel;

    assign cx       = scr_w_reg[12:1];
    assign cy       = scr_h_reg[12:1];
    assign x_off    = $signed({2'b00, mx_reg}) - $signed({2'b00, cx});
    assign y_off    = $signed({2'b00, cy}) - $signed({2'b00, my_reg});
    assign wrap_num = (ang_reg >>> 16) + WRAP_BIAS;
    assign trig_num = 32'(prod_reg >>> 16) + IDX_BIAS;
    assign quot     = 27'(prod_reg >>> RECIP_SHIFT);
    assign wrap_rem = wrap_num - 32'(quot) * 32'sd360;
    assign yaw_wrap = (wrap_rem <<< 16) + $signed({16'h0000, ang_reg[15:0]}) - HALF_TURN;
    assign idx_raw  = 15'(quot) - IDX_OFF;

    // Fold the rounded step into the table range.
    always_comb begin
        if (idx_raw < 0) begin
            idx_fix = idx_raw + DEPTH_S;
        end else if (idx_raw >= DEPTH_S) begin
            idx_fix = idx_raw - DEPTH_S;
        end else begin
            idx_fix = idx_raw;
        end
    end

    // Angle being converted to a table step.
    always_comb begin
        case (cmd.lane)
            LANE_YAW:   deg_sel = 33'(yaw_reg);
            LANE_PITCH: deg_sel = 33'(pitch_reg);
            default:    deg_sel = 33'($signed({roll_reg, 16'h0000}));
        endcase
    end

    // Move terms: forward for fwd/back, right for left/right.
    assign mv_vec = (func_reg == FN_LEFT || func_reg == FN_RIGHT) ? rgt_reg[cmd.lane]
                                                                 : fwd_reg[cmd.lane];
    assign mv_neg = (func_reg == FN_BACK || func_reg == FN_LEFT);
    assign mv_d   = rnd_shift(60'(prod_reg), 5'd14);
    assign pos_sum = 34'(pos_reg[cmd.lane]) + (mv_neg ? -34'(mv_d) : 34'(mv_d));
    assign vert_sum = (func_reg == FN_DOWN) ?
                      34'(pos_reg[1]) - $signed({17'h00000, dt_reg, 1'b0}) :
                      34'(pos_reg[1]) + $signed({17'h00000, dt_reg, 1'b0});
    assign ang_sum   = 34'(yaw_reg) + 34'(prod_reg <<< 2) + 34'(HALF_TURN);
    assign pitch_sum = 34'(pitch_reg) + 34'(prod_reg <<< 2);

    // Multiplier operand selection.
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b0;
        case (cmd.op)
            OP_MOVE_MUL: begin
                mul_a  = 33'(mv_vec);
                mul_b  = $signed({9'h000, dt_reg});
                mul_en = 1'b1;
            end
            OP_YAW_MUL: begin
                mul_a  = $signed({17'h00000, dt_reg});
                mul_b  = 25'(x_off);
                mul_en = 1'b1;
            end
            OP_YAW_SUM: begin
                mul_a  = $signed({17'h00000, dt_reg});
                mul_b  = 25'(y_off);
                mul_en = 1'b1;
            end
            OP_PITCH_SUM: begin
                mul_a  = 33'(wrap_num);
                mul_b  = RECIP_360;
                mul_en = 1'b1;
            end
            OP_TRIG_MUL: begin
                mul_a  = deg_sel;
                mul_b  = 25'(SINE_TABLE_DEPTH);
                mul_en = 1'b1;
            end
            OP_TRIG_RECIP: begin
                mul_a  = 33'(trig_num);
                mul_b  = RECIP_360;
                mul_en = 1'b1;
            end
            OP_VEC: begin
                mul_en = 1'b1;
                case (cmd.step)
                    4'd0: begin
                        mul_a = 33'(sin_reg[LANE_YAW]);
                        mul_b = 25'(cos_reg[LANE_PITCH]);
                    end
                    4'd1: begin
                        mul_a = 33'(cos_reg[LANE_PITCH]);
                        mul_b = 25'(cos_reg[LANE_YAW]);
                    end
                    4'd2: begin
                        mul_a = 33'(cos_reg[LANE_PITCH]);
                        mul_b = 25'(cos_reg[LANE_ROLL]);
                    end
                    4'd3: begin
                        mul_a = 33'(cos_reg[LANE_YAW]);
                        mul_b = 25'(sin_reg[LANE_ROLL]);
                    end
                    4'd4: begin
                        mul_a = 33'(sin_reg[LANE_PITCH]);
                        mul_b = 25'(cos_reg[LANE_ROLL]);
                    end
                    4'd5: begin
                        mul_a = $signed(prod_reg[32:0]);
                        mul_b = 25'(sin_reg[LANE_YAW]);
                    end
                    4'd6: begin
                        mul_a = 33'(sin_reg[LANE_YAW]);
                        mul_b = 25'(sin_reg[LANE_ROLL]);
                    end
                    4'd7: begin
                        mul_a = 33'(w_reg);
                        mul_b = 25'(cos_reg[LANE_YAW]);
                    end
                    4'd9: begin
                        mul_a = 33'(fwd_reg[1]);
                        mul_b = 25'(up_reg[2]);
                    end
                    4'd10: begin
                        mul_a = 33'(fwd_reg[2]);
                        mul_b = 25'(up_reg[1]);
                    end
                    4'd11: begin
                        mul_a = 33'(fwd_reg[2]);
                        mul_b = 25'(up_reg[0]);
                    end
                    4'd12: begin
                        mul_a = 33'(fwd_reg[0]);
                        mul_b = 25'(up_reg[2]);
                    end
                    4'd13: begin
                        mul_a = 33'(fwd_reg[0]);
                        mul_b = 25'(up_reg[1]);
                    end
                    4'd14: begin
                        mul_a = 33'(fwd_reg[1]);
                        mul_b = 25'(up_reg[0]);
                    end
                    default: begin
                        mul_en = 1'b0;
                    end
                endcase
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Next values of all registers.
    always_comb begin
        func_next  = func_reg;
        dt_next    = dt_reg;
        mx_next    = mx_reg;
        my_next    = my_reg;
        scr_w_next = scr_w_reg;
        scr_h_next = scr_h_reg;
        roll_next  = roll_reg;
        pos_next   = pos_reg;
        fwd_next   = fwd_reg;
        up_next    = up_reg;
        rgt_next   = rgt_reg;
        yaw_next   = yaw_reg;
        pitch_next = pitch_reg;
        ang_next   = ang_reg;
        prod_next  = mul_en ? mul_p : prod_reg;
        acc_next   = acc_reg;
        w_next     = w_reg;
        idx_next   = idx_reg;
        sin_next   = sin_reg;
        cos_next   = cos_reg;
        out_next   = out_reg;

        // Configuration writes; unknown indexes are ignored.
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SCREEN_W: scr_w_next = cfg_wdata;
                CFG_SCREEN_H: scr_h_next = cfg_wdata;
                CFG_ROLL:     roll_next  = $signed(cfg_wdata[8:0]);
                default:      ;
            endcase
        end

        case (cmd.op)
            OP_LOAD: begin
                func_next = s_tuser;
                dt_next   = s_tdata[15:0];
                mx_next   = s_tdata[27:16];
                my_next   = s_tdata[39:28];
            end
            OP_MOVE_ADD: begin
                pos_next[cmd.lane] = sat_pos(pos_sum);
            end
            OP_VERT: begin
                pos_next[1] = sat_pos(vert_sum);
            end
            OP_YAW_SUM: begin
                ang_next = ang_sum[31:0];
            end
            OP_PITCH_SUM: begin
                if (pitch_sum > 34'(PITCH_LIM)) begin
                    pitch_next = PITCH_LIM;
                end else if (pitch_sum < -34'(PITCH_LIM)) begin
                    pitch_next = -PITCH_LIM;
                end else begin
                    pitch_next = pitch_sum[24:0];
                end
            end
            OP_YAW_WRAP: begin
                yaw_next = yaw_wrap[24:0];
            end
            OP_TRIG_IDX: begin
                idx_next = idx_fix[IDX_W-1:0];
            end
            OP_TRIG_ROM: begin
                sin_next[cmd.lane] = sin_rom[idx_reg];
                cos_next[cmd.lane] = cos_rom[idx_reg];
            end
            OP_VEC: begin
                case (cmd.step)
                    4'd1: begin
                        fwd_next[0] = sat_vec(rnd_shift(60'(prod_reg), 5'd14));
                        fwd_next[1] = sat_vec(60'(sin_reg[LANE_PITCH]));
                    end
                    4'd2: fwd_next[2] = sat_vec(-rnd_shift(60'(prod_reg), 5'd14));
                    4'd3: up_next[1]  = sat_vec(rnd_shift(60'(prod_reg), 5'd14));
                    4'd4: acc_next    = 48'(-(60'(prod_reg) <<< 14));
                    4'd5: w_next      = prod_reg[29:0];
                    4'd6: up_next[0]  = sat_vec(rnd_shift(60'(acc_reg) - 60'(prod_reg), 5'd28));
                    4'd7: acc_next    = 48'(-(60'(prod_reg) <<< 14));
                    4'd8: up_next[2]  = sat_vec(rnd_shift(60'(acc_reg) + 60'(prod_reg), 5'd28));
                    4'd10, 4'd12, 4'd14: acc_next = 48'(prod_reg);
                    4'd11: rgt_next[0] = sat_vec(rnd_shift(60'(acc_reg) - 60'(prod_reg), 5'd14));
                    4'd13: rgt_next[1] = sat_vec(rnd_shift(60'(acc_reg) - 60'(prod_reg), 5'd14));
                    4'd15: rgt_next[2] = sat_vec(rnd_shift(60'(acc_reg) - 60'(prod_reg), 5'd14));
                    default: ;
                endcase
            end
            OP_OUT: begin
                out_next = {rgt_reg[2], rgt_reg[1], rgt_reg[0],
                            up_reg[2], up_reg[1], up_reg[0],
                            fwd_reg[2], fwd_reg[1], fwd_reg[0],
                            pos_reg[2], pos_reg[1], pos_reg[0]};
            end
            default: ;
        endcase
    end

    // Pose, angles and configuration take their reset values.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scr_w_reg <= 13'd1280;
            scr_h_reg <= 13'd720;
            roll_reg  <= 9'sd0;
            pos_reg   <= '{32'sd0, 32'sd32768, -32'sd131072};
            fwd_reg   <= '{16'sd0, 16'sd0, V_ONE};
            up_reg    <= '{16'sd0, V_ONE, 16'sd0};
            rgt_reg   <= '{V_ONE, 16'sd0, 16'sd0};
            yaw_reg   <= YAW_RST;
            pitch_reg <= PITCH_RST;
        end else begin
            scr_w_reg <= scr_w_next;
            scr_h_reg <= scr_h_next;
            roll_reg  <= roll_next;
            pos_reg   <= pos_next;
            fwd_reg   <= fwd_next;
            up_reg    <= up_next;
            rgt_reg   <= rgt_next;
            yaw_reg   <= yaw_next;
            pitch_reg <= pitch_next;
        end
    end

    // Working and payload registers need no reset.
    always_ff @(posedge aclk) begin
        func_reg <= func_next;
        dt_reg   <= dt_next;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        ang_reg  <= ang_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        w_reg    <= w_next;
        idx_reg  <= idx_next;
        sin_reg  <= sin_next;
        cos_reg  <= cos_next;
        out_reg  <= out_next;
    end

    assign m_tdata = out_reg;

endmodule

`default_nettype wire

// ----- hdl/euler_camera_basis_update.sv -----
// Camera pose update: moves along forward/right/vertical and yaw/pitch turns.
// Unused codes go straight to the output register; vertical moves add to pos_y,
// forward/right moves multiply and add per axis, and a turn steps the single
// shared multiplier through angle, table and basis math. A new word can be
// taken in the cycle after the result is loaded. Reset (aresetn low,
// synchronous) restores the start pose, angles, configuration and controller state.
`default_nettype none

module euler_camera_basis_update
    import ecbu_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [39:0]  s_tdata,   // dt[15:0], mouse_x[27:16], mouse_y[39:28]
    input  wire logic [2:0]   s_tuser,   // func[2:0]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [239:0]      m_tdata,   // pos_x, pos_y, pos_z (32 each), fwd_x..z,
                                         // up_vx..vz, right_vx..vz (16 each)
    input  wire logic         cfg_wr_en,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [12:0]  cfg_wdata
);

    cmd_t cmd;

    // Sequencer.
    ecbu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Arithmetic and state.
    ecbu_datapath #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire
